/* hw/rtl/blc_pkg.sv */
package blc_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 8;
   localparam int LEVEL_W  = 8;
   localparam int PERIOD_W = 7;
   localparam int COLOR_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_COMMAND    = 3'd0,
      MODE_LIVE       = 3'd1,
      MODE_TICK       = 3'd2,
      MODE_DISCONNECT = 3'd3,
      MODE_CONNECT    = 3'd4
   } mode_type;

   localparam logic [VALUE_W-1:0] CMD_RED        = 8'd0;
   localparam logic [VALUE_W-1:0] CMD_GREEN      = 8'd1;
   localparam logic [VALUE_W-1:0] CMD_BLUE       = 8'd2;
   localparam logic [VALUE_W-1:0] CMD_PERIOD_DN  = 8'd3;
   localparam logic [VALUE_W-1:0] CMD_PERIOD_UP  = 8'd4;
   localparam logic [VALUE_W-1:0] CMD_LEVEL_DN   = 8'd5;
   localparam logic [VALUE_W-1:0] CMD_LEVEL_UP   = 8'd6;
   localparam logic [VALUE_W-1:0] CMD_CEIL_DN    = 8'd7;
   localparam logic [VALUE_W-1:0] CMD_CEIL_UP    = 8'd8;
   localparam logic [VALUE_W-1:0] CMD_RESTORE    = 8'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_BRIGHTNESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PERIOD     = 1'b1;

   localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;

   localparam logic [LEVEL_W-1:0]  RST_LEVEL       = 8'd90;
   localparam logic [PERIOD_W-1:0] RST_PERIOD      = 7'd40;
   localparam logic [LEVEL_W-1:0]  LEVEL_STEP      = 8'd20;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 8'd255;
   localparam logic [LEVEL_W-1:0]  RESTORE_LEVEL   = 8'd100;
   localparam logic [PERIOD_W-1:0] PERIOD_STEP     = 7'd10;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN      = 7'd10;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 7'd100;
   localparam logic [PERIOD_W-1:0] RESTORE_PERIOD  = 7'd50;

   typedef struct packed {
      logic [LEVEL_W-1:0]  ceiling_level;
      logic [LEVEL_W-1:0]  level;
      logic                ramp_up;
      logic [PERIOD_W-1:0] pulse_period;
      logic [PERIOD_W-1:0] elapsed_ticks;
      logic                pulse_running;
      logic [LEVEL_W-1:0]  strip_level;
      logic [COLOR_W-1:0]  strip_color;
   } state_type;

   typedef struct packed {
      logic                pulse_step_done;
      logic [PERIOD_W-1:0] period_now;
      logic [LEVEL_W-1:0]  ceiling_now;
      logic                pulse_active;
      logic [COLOR_W-1:0]  color_code;
      logic [LEVEL_W-1:0]  shown_brightness;
   } result_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  idle_brightness;
      logic [PERIOD_W-1:0] idle_pulse_period;
   } cfg_type;

endpackage

/* hw/rtl/blc_core.sv */
module blc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  blc_pkg::mode_type       mode,
   input  logic [7:0]              value,
   input  blc_pkg::cfg_type        cfg,
   output blc_pkg::result_type     result
);
   import blc_pkg::*;

   state_type state_ff, state_in;
   logic      stepped;

   logic [15:0]          product;
   logic [16:0]          quot_sum;
   logic [LEVEL_W-1:0]   live_level;
   logic [PERIOD_W-1:0]  elapsed_inc;
   logic [PERIOD_W-1:0]  idle_period;
   logic [PERIOD_W:0]    period_up;
   logic [LEVEL_W:0]     level_up20;
   logic [LEVEL_W:0]     level_up1;
   logic [LEVEL_W:0]     ceil_up20;

   // x*ceiling/255 via reciprocal: (n + n>>8 + 1) >> 8 is exact for n up to 255*255
   assign product    = 16'(value) * 16'(state_ff.ceiling_level);
   assign quot_sum   = 17'(product) + 17'(product[15:8]) + 17'd1;
   assign live_level = (value != '0 && quot_sum[15:8] == '0) ? 8'd1 : quot_sum[15:8];

   assign elapsed_inc = state_ff.elapsed_ticks + 7'd1;
   assign period_up   = {1'b0, state_ff.pulse_period} + {1'b0, PERIOD_STEP};
   assign level_up20  = {1'b0, state_ff.level} + {1'b0, LEVEL_STEP};
   assign level_up1   = {1'b0, state_ff.level} + 9'd1;
   assign ceil_up20   = {1'b0, state_ff.ceiling_level} + {1'b0, LEVEL_STEP};

   assign idle_period = (cfg.idle_pulse_period < PERIOD_MIN) ? PERIOD_MIN :
                        (cfg.idle_pulse_period > PERIOD_MAX) ? PERIOD_MAX :
                        cfg.idle_pulse_period;

   always_comb begin
      state_in = state_ff;
      stepped  = 1'b0;
      if (advance) begin
         unique case (mode)
            MODE_COMMAND: begin
               unique case (value)
                  CMD_RED, CMD_GREEN, CMD_BLUE: begin
                     state_in.strip_color = value[COLOR_W-1:0];
                  end
                  CMD_PERIOD_DN, CMD_PERIOD_UP: begin
                     if (value == CMD_PERIOD_DN) begin
                        state_in.pulse_period = (state_ff.pulse_period <= 7'd20) ? PERIOD_MIN :
                                                state_ff.pulse_period - PERIOD_STEP;
                     end else begin
                        state_in.pulse_period = (period_up >= {1'b0, PERIOD_MAX}) ? PERIOD_MAX :
                                                period_up[PERIOD_W-1:0];
                     end
                     if (!state_ff.pulse_running) begin
                        state_in.pulse_running = 1'b1;
                        state_in.elapsed_ticks = '0;
                     end
                  end
                  CMD_LEVEL_DN: begin
                     state_in.level = (state_ff.level <= LEVEL_STEP) ? '0 :
                                      state_ff.level - LEVEL_STEP;
                     state_in.strip_level = state_in.level;
                  end
                  CMD_LEVEL_UP: begin
                     state_in.level = (level_up20 >= {1'b0, state_ff.ceiling_level}) ?
                                      state_ff.ceiling_level : level_up20[LEVEL_W-1:0];
                     state_in.strip_level = state_in.level;
                  end
                  CMD_CEIL_DN: begin
                     state_in.ceiling_level = (state_ff.ceiling_level <= 8'd21) ? 8'd1 :
                                              state_ff.ceiling_level - LEVEL_STEP;
                  end
                  CMD_CEIL_UP: begin
                     state_in.ceiling_level = (ceil_up20 >= {1'b0, LEVEL_MAX}) ? LEVEL_MAX :
                                              ceil_up20[LEVEL_W-1:0];
                  end
                  CMD_RESTORE: begin
                     state_in.pulse_running = 1'b0;
                     state_in.ceiling_level = RESTORE_LEVEL;
                     state_in.level         = RESTORE_LEVEL;
                     state_in.pulse_period  = RESTORE_PERIOD;
                  end
                  default: begin
                  end
               endcase
            end
            MODE_LIVE: begin
               state_in.pulse_running = 1'b0;
               state_in.strip_level   = live_level;
            end
            MODE_TICK: begin
               if (state_ff.pulse_running) begin
                  if (elapsed_inc < state_ff.pulse_period) begin
                     state_in.elapsed_ticks = elapsed_inc;
                  end else begin
                     stepped = 1'b1;
                     state_in.elapsed_ticks = '0;
                     if (state_ff.ramp_up) begin
                        if (level_up1 >= {1'b0, state_ff.ceiling_level}) begin
                           state_in.level   = state_ff.ceiling_level;
                           state_in.ramp_up = 1'b0;
                        end else begin
                           state_in.level = level_up1[LEVEL_W-1:0];
                        end
                     end else begin
                        if (state_ff.level <= 8'd2) begin
                           state_in.level   = 8'd1;
                           state_in.ramp_up = 1'b1;
                        end else begin
                           state_in.level = state_ff.level - 8'd1;
                        end
                     end
                     state_in.strip_level = state_in.level;
                  end
               end
            end
            MODE_DISCONNECT: begin
               // stop then restart: timer always starts over from zero
               state_in.strip_level   = cfg.idle_brightness;
               state_in.strip_color   = COLOR_RED;
               state_in.pulse_period  = idle_period;
               state_in.pulse_running = 1'b1;
               state_in.elapsed_ticks = '0;
            end
            MODE_CONNECT: begin
               state_in.strip_color   = COLOR_GREEN;
               state_in.pulse_running = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.ceiling_level <= RST_LEVEL;
         state_ff.level         <= RST_LEVEL;
         state_ff.ramp_up       <= 1'b1;
         state_ff.pulse_period  <= RST_PERIOD;
         state_ff.elapsed_ticks <= '0;
         state_ff.pulse_running <= 1'b1;
         state_ff.strip_level   <= RST_LEVEL;
         state_ff.strip_color   <= COLOR_RED;
      end else begin
         state_ff <= state_in;
      end
   end

   assign result.shown_brightness = state_in.strip_level;
   assign result.color_code       = state_in.strip_color;
   assign result.pulse_active     = state_in.pulse_running;
   assign result.ceiling_now      = state_in.ceiling_level;
   assign result.period_now       = state_in.pulse_period;
   assign result.pulse_step_done  = stepped;

   a_step_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      stepped |-> (mode == MODE_TICK && state_ff.pulse_running))
      else $error("ramp step outside a running tick");

   a_period_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.pulse_period >= PERIOD_MIN && state_ff.pulse_period <= PERIOD_MAX)
      else $error("pulse period out of range");

   a_ceiling_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.ceiling_level != '0)
      else $error("ceiling reached zero");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> state_ff == $past(state_ff))
      else $error("state changed without a word");

endmodule

/* hw/rtl/breathing_led_brightness_controller_unit.sv */
// A word accepted on req_ passes the input register, then the result
// register, to rsp_. The state update loops through one register.
// Throughput: one word per cycle while rsp_tready does not stall results.
// Output register lets a new word enter while a result waits on rsp_tready.
// Reset (synchronous, active high) empties both registers and restores the
// default level, ceiling, period, color and idle settings.
module breathing_led_brightness_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [blc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] value
   input  logic [blc_pkg::REQ_USER_W-1:0]  req_tuser,   // [2:0] mode, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] shown_brightness, [9:8] color_code, [10] pulse_active,
   // [18:11] ceiling_now, [25:19] period_now, [26] pulse_step_done
   output logic [blc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [blc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [blc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import blc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   mode_type           in_mode_ff;
   logic [VALUE_W-1:0] in_value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, result;
   cfg_type            cfg_ff, cfg_in;
   logic               advance;
   logic               req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_BRIGHTNESS: cfg_in.idle_brightness   = csr_wdata[LEVEL_W-1:0];
            CSR_IDLE_PERIOD:     cfg_in.idle_pulse_period = csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         cfg_ff.idle_brightness   <= RST_LEVEL;
         cfg_ff.idle_pulse_period <= RST_PERIOD;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff  <= mode_type'(req_tuser[MODE_W-1:0]);
         in_value_ff <= req_tdata[VALUE_W-1:0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   blc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .mode    (in_mode_ff),
      .value   (in_value_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.pulse_step_done, rsp_data_ff.period_now,
                        rsp_data_ff.ceiling_now, rsp_data_ff.pulse_active,
                        rsp_data_ff.color_code, rsp_data_ff.shown_brightness};

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("pending result lost");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_value_ff)))
      else $error("stalled word lost");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result not registered");

endmodule

/* tb/sv/breathing_led_brightness_controller_unit_tb.sv */
module breathing_led_brightness_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import blc_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // [7:0] value
   logic [REQ_USER_W-1:0]  req_tuser = '0;   // [2:0] mode, rest zero
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] shown_brightness, [9:8] color_code, [10] pulse_active,
   // [18:11] ceiling_now, [25:19] period_now, [26] pulse_step_done
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   breathing_led_brightness_controller_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // strip model
   logic [LEVEL_W-1:0]  idle_bright_q;
   logic [PERIOD_W-1:0] idle_period_q;
   logic [LEVEL_W-1:0]  ceil_q;
   logic [LEVEL_W-1:0]  lvl_q;
   logic                rising_q;
   logic [PERIOD_W-1:0] period_q;
   logic [PERIOD_W-1:0] tick_cnt_q;
   logic                breathing_q;
   logic [LEVEL_W-1:0]  shown_q;
   logic [COLOR_W-1:0]  color_q;

   result_type expected_strip[$];

   int  mismatches = 0;
   int  words_sent = 0;
   int  results_seen = 0;
   int  ramp_steps = 0;
   int  rsp_hold = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic void start_breathing(input int p);
      period_q = p[PERIOD_W-1:0];
      if (!breathing_q) begin
         breathing_q = 1'b1;
         tick_cnt_q  = '0;
      end
   endfunction

   function automatic void apply_command(input logic [VALUE_W-1:0] code);
      int lv, cl, pd;
      lv = lvl_q;
      cl = ceil_q;
      pd = period_q;
      case (code)
         CMD_RED, CMD_GREEN, CMD_BLUE: color_q = code[COLOR_W-1:0];
         CMD_PERIOD_DN:
            start_breathing(pd <= PERIOD_MIN + PERIOD_STEP ? PERIOD_MIN : pd - PERIOD_STEP);
         CMD_PERIOD_UP:
            start_breathing(pd + PERIOD_STEP >= PERIOD_MAX ? PERIOD_MAX : pd + PERIOD_STEP);
         CMD_LEVEL_DN: begin
            lvl_q   = lv <= LEVEL_STEP ? 8'd0 : 8'(lv - LEVEL_STEP);
            shown_q = lvl_q;
         end
         CMD_LEVEL_UP: begin
            lvl_q   = lv + LEVEL_STEP >= cl ? ceil_q : 8'(lv + LEVEL_STEP);
            shown_q = lvl_q;
         end
         CMD_CEIL_DN: ceil_q = cl <= LEVEL_STEP + 1 ? 8'd1 : 8'(cl - LEVEL_STEP);
         CMD_CEIL_UP: ceil_q = cl + LEVEL_STEP >= LEVEL_MAX ? LEVEL_MAX : 8'(cl + LEVEL_STEP);
         CMD_RESTORE: begin
            breathing_q = 1'b0;
            ceil_q      = RESTORE_LEVEL;
            lvl_q       = RESTORE_LEVEL;
            period_q    = RESTORE_PERIOD;
         end
         default: ;
      endcase
   endfunction

   // advances the model by one word and returns what the strip shows after it
   function automatic result_type next_strip_state(input logic [MODE_W-1:0] m,
                                                   input logic [VALUE_W-1:0] v);
      result_type r;
      logic       stepped;
      int         t, lv, cl;
      stepped = 1'b0;
      case (m)
         MODE_COMMAND: apply_command(v);
         MODE_LIVE: begin
            t = (int'(v) * int'(ceil_q)) / 255;
            if (v != 0 && t == 0) t = 1;
            breathing_q = 1'b0;
            shown_q     = t[LEVEL_W-1:0];
         end
         MODE_TICK: begin
            if (breathing_q) begin
               tick_cnt_q = tick_cnt_q + 1'b1;
               if (tick_cnt_q >= period_q) begin
                  tick_cnt_q = '0;
                  lv = lvl_q;
                  cl = ceil_q;
                  if (rising_q) begin
                     if (lv + 1 >= cl) begin
                        lvl_q    = ceil_q;
                        rising_q = 1'b0;
                     end else begin
                        lvl_q = 8'(lv + 1);
                     end
                  end else begin
                     if (lv <= 2) begin
                        lvl_q    = 8'd1;
                        rising_q = 1'b1;
                     end else begin
                        lvl_q = 8'(lv - 1);
                     end
                  end
                  shown_q = lvl_q;
                  stepped = 1'b1;
               end
            end
         end
         MODE_DISCONNECT: begin
            t = idle_period_q;
            if (t < PERIOD_MIN) t = PERIOD_MIN;
            if (t > PERIOD_MAX) t = PERIOD_MAX;
            breathing_q = 1'b0;
            shown_q     = idle_bright_q;
            color_q     = COLOR_RED;
            start_breathing(t);
         end
         MODE_CONNECT: begin
            color_q     = COLOR_GREEN;
            breathing_q = 1'b0;
         end
         default: ;
      endcase
      r.shown_brightness = shown_q;
      r.color_code       = color_q;
      r.pulse_active     = breathing_q;
      r.ceiling_now      = ceil_q;
      r.period_now       = period_q;
      r.pulse_step_done  = stepped;
      return r;
   endfunction

   // call at a rising edge; returns at the edge where the word was taken
   task automatic send_word(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= {{(REQ_USER_W-MODE_W){1'b0}}, m};
      do @(posedge clock); while (!req_tready);
      expected_strip.push_back(next_strip_state(m, v));
      words_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_strip.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IDLE_BRIGHTNESS) idle_bright_q = d;
      else idle_period_q = d[PERIOD_W-1:0];
      @(posedge clock);
   endtask

   task automatic test_directed_items();
      send_word(MODE_TICK, 8'h00);
      send_word(MODE_COMMAND, CMD_BLUE);
      send_word(MODE_COMMAND, CMD_GREEN);
      send_word(MODE_COMMAND, CMD_RED);
      send_word(MODE_COMMAND, CMD_PERIOD_DN);
      send_word(MODE_COMMAND, CMD_PERIOD_UP);
      send_word(MODE_COMMAND, CMD_LEVEL_UP);
      send_word(MODE_COMMAND, CMD_LEVEL_DN);
      send_word(MODE_COMMAND, CMD_CEIL_UP);
      send_word(MODE_COMMAND, CMD_CEIL_DN);
      send_word(MODE_COMMAND, CMD_RESTORE);
      send_word(MODE_COMMAND, 8'd10);     // unknown codes
      send_word(MODE_COMMAND, 8'd255);
      send_word(MODE_LIVE, 8'd0);
      send_word(MODE_LIVE, 8'd1);
      send_word(MODE_LIVE, 8'd255);
      send_word(MODE_LIVE, 8'd128);
      send_word(MODE_DISCONNECT, 8'h55);
      send_word(MODE_TICK, 8'hAA);
      send_word(MODE_CONNECT, 8'hFF);
      send_word(3'd5, 8'hAA);             // unknown modes
      send_word(3'd6, 8'h55);
      send_word(3'd7, 8'hFF);
      wait_idle();
   endtask

   task automatic test_idle_settings();
      // zero brightness is shown as is, short periods clamp up, long ones down
      write_reg(CSR_IDLE_BRIGHTNESS, 8'd0);
      write_reg(CSR_IDLE_PERIOD, 8'd0);
      send_word(MODE_DISCONNECT, 8'h00);
      repeat (11) send_word(MODE_TICK, 8'h00);
      wait_idle();
      write_reg(CSR_IDLE_BRIGHTNESS, 8'd255);
      write_reg(CSR_IDLE_PERIOD, 8'hFF);
      send_word(MODE_DISCONNECT, 8'h00);
      send_word(MODE_CONNECT, 8'h00);
      wait_idle();
   endtask

   task automatic test_output_stall();
      req_gaps_on = 1'b0;
      rsp_hold    = 300;
      repeat (40) send_word(MODE_TICK, 8'($urandom_range(0, 255)));
      wait_idle();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_phase(input logic [7:0] ib, input logic [7:0] ip,
                                    input int count, input int tick_pct, input bit gaps);
      int r;
      logic [MODE_W-1:0]  m;
      logic [VALUE_W-1:0] v;
      wait_idle();
      write_reg(CSR_IDLE_BRIGHTNESS, ib);
      write_reg(CSR_IDLE_PERIOD, ip);
      req_gaps_on = gaps;
      rsp_gaps_on = gaps;
      repeat (count) begin
         v = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < tick_pct) begin
            m = MODE_TICK;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               m = MODE_COMMAND;
               r = $urandom_range(0, 99);
               if (r < 20) v = CMD_PERIOD_DN;
               else if (r < 88) v = 8'($urandom_range(0, 9));
            end else if (r < 70) begin
               m = MODE_LIVE;
               r = $urandom_range(0, 9);
               if (r == 0) v = 8'd0;
               else if (r == 1) v = 8'd255;
            end else if (r < 80) begin
               m = MODE_DISCONNECT;
            end else if (r < 90) begin
               m = MODE_CONNECT;
            end else begin
               m = 3'($urandom_range(5, 7));
            end
         end
         send_word(m, v);
      end
      wait_idle();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // result side ready: random stalls plus an optional long hold-off
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 99) < 25) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type got, want;
      bit         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         results_seen++;
         if (expected_strip.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = expected_strip.pop_front();
            if (want.pulse_step_done) ramp_steps++;
            bad = (got.shown_brightness !== want.shown_brightness) ||
                  (got.color_code       !== want.color_code) ||
                  (got.pulse_active     !== want.pulse_active) ||
                  (got.ceiling_now      !== want.ceiling_now) ||
                  (got.period_now       !== want.period_now) ||
                  (got.pulse_step_done  !== want.pulse_step_done);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("result %0d: exp lvl=%0d col=%0d run=%0b ceil=%0d per=%0d step=%0b",
                         results_seen,
                         want.shown_brightness, want.color_code, want.pulse_active,
                         want.ceiling_now, want.period_now, want.pulse_step_done);
                  $display(" got lvl=%0d col=%0d run=%0b ceil=%0d per=%0d step=%0b",
                           got.shown_brightness, got.color_code, got.pulse_active,
                           got.ceiling_now, got.period_now, got.pulse_step_done);
               end
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d results outstanding", expected_strip.size());
      $display("breathing_led_brightness_controller_unit_tb failed");
      $finish;
   end

   initial begin
      idle_bright_q = RST_LEVEL;
      idle_period_q = RST_PERIOD;
      ceil_q        = RST_LEVEL;
      lvl_q         = RST_LEVEL;
      rising_q      = 1'b1;
      period_q      = RST_PERIOD;
      tick_cnt_q    = '0;
      breathing_q   = 1'b1;
      shown_q       = RST_LEVEL;
      color_q       = COLOR_RED;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_items();
      test_idle_settings();
      test_output_stall();
      test_random_phase(8'd90,  8'd40,  150, 50, 1'b1);
      test_random_phase(8'd0,   8'd0,   150, 70, 1'b1);
      test_random_phase(8'd255, 8'hFF,  150, 50, 1'b1);
      test_random_phase(8'd1,   8'd10,  150, 80, 1'b0);
      test_random_phase(8'd128, 8'd100, 150, 60, 1'b1);
      test_random_phase(8'd37,  8'd5,   150, 85, 1'b1);
      test_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        150, 65, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("sent %0d words (commands, live bytes, ticks, link events, bad modes)",
               words_sent);
      $display("checked %0d results, %0d ramp steps, %0d mismatches, %0d left over",
               results_seen, ramp_steps, mismatches, expected_strip.size());
      if (mismatches == 0 && expected_strip.size() == 0)
         $display("breathing_led_brightness_controller_unit_tb passed");
      else
         $display("breathing_led_brightness_controller_unit_tb failed");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/blc_pkg.sv
hw/rtl/blc_core.sv
hw/rtl/breathing_led_brightness_controller_unit.sv
tb/sv/breathing_led_brightness_controller_unit_tb.sv
